// ----- design/vbsd_pkg.sv -----
`timescale 1ns / 1ps
package vbsd_pkg;
  localparam int LENGTH_BITS_DEF = 24;

  typedef enum logic [1:0] {
    K_RUN  = 2'd0,
    K_RATE = 2'd1,
    K_END  = 2'd2,
    K_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    E_BAD_TYPE = 3'd0,
    E_NO_SIZE  = 3'd1,
    E_TOO_LONG = 3'd2,
    E_CONFLICT = 3'd3,
    E_COMPRESS = 3'd4,
    E_TRUNC    = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_SIZE = 3'd1,
    PH_RATE = 3'd2,
    PH_COMP = 3'd3,
    PH_DATA = 3'd4,
    PH_SKIP = 3'd5,
    PH_FIX  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_END = 2'd1,
    ST_ERR = 2'd2
  } status_t;

  // one queued command from the front part
  typedef enum logic [2:0] {
    OP_RUN     = 3'd0,  // sample run, no division
    OP_END     = 3'd1,
    OP_ERR     = 3'd2,
    OP_RATE_SB = 3'd3,  // sound block rate, comp check follows
    OP_RATE_TC = 3'd4,  // time constant rate
    OP_NONE    = 3'd5
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] sample;
    logic [16:0] run;
    logic [27:0] dividend;
    logic [16:0] divisor;
    err_t        err;
    logic        comp_bad;  // compression byte nonzero
    logic        tail;      // a trailing end or truncation follows
    logic        tail_end;  // 1 clean end, 0 truncated
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] sample;
    logic [16:0] run;
    logic [27:0] rate;
    logic [2:0]  err;
    logic        last;
  } res_t;
endpackage

// ----- design/voc_block_stream_decoder.sv -----
`timescale 1ns / 1ps
// VOC block stream parser: one byte per transfer on data_byte, results on the
// output channel with last marking the final result of a byte. A byte that
// gives no result is taken every cycle while the command queue is empty; a byte
// that gives a result holds the one-entry command queue, so the next byte waits
// until the back part has sent every result of that byte and popped the queue,
// including any time the output is stalled. Rate bytes and time constants pass a
// 28-step restoring divider in the back part. Writing stream_length restarts.
module voc_block_stream_decoder import vbsd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             kind,
  output logic signed [15:0]     sample,
  output logic [16:0]            run_length,
  output logic [27:0]            rate_hz,
  output logic [2:0]             error_code,
  output logic                   last
);
  logic [LENGTH_BITS-1:0] stream_length;
  wire wr = psel && penable && pwrite;
  wire restart = wr && paddr == 2'd0;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(stream_length) : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) stream_length <= '0;
    else if (restart) stream_length <= LENGTH_BITS'(pwdata[23:0]);
  end

  logic fv, qv, qfull, pop, halted;
  cmd_t fc, qc;
  res_t res;

  vbsd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst, .restart, .length(LENGTH_BITS'(pwdata[23:0])),
    .in_valid, .in_byte(data_byte), .in_stall,
    .q_valid(fv), .q_cmd(fc), .q_full(qfull), .halted
  );
  vbsd_queue u_queue (
    .clk, .rst(rst || restart), .push(fv), .din(fc), .pop, .valid(qv), .dout(qc),
    .full(qfull)
  );
  vbsd_back u_back (
    .clk, .rst, .restart, .q_valid(qv), .q_cmd(qc), .q_pop(pop), .halted,
    .out_valid, .out_res(res), .out_stall
  );

  assign kind = res.kind[1:0];
  assign sample = res.sample;
  assign run_length = res.run;
  assign rate_hz = res.rate;
  assign error_code = res.err;
  assign last = res.last;
endmodule

// ----- design/vbsd_front.sv -----
`timescale 1ns / 1ps
module vbsd_front import vbsd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  logic [LENGTH_BITS-1:0] length,
  input  logic                   in_valid,
  input  logic [7:0]             in_byte,
  output logic                   in_stall,
  output logic                   q_valid,
  output cmd_t                   q_cmd,
  input  logic                   q_full,
  input  logic                   halted
);
  phase_t phase;
  logic [3:0] block_kind;
  logic [23:0] block_remaining;
  logic [LENGTH_BITS-1:0] bytes_left;
  logic [23:0] field_assembly;
  logic [7:0] rate_byte;
  logic done;  // front stopped, rest decided by back part

  phase_t phase_next;
  logic [3:0] kind_next;
  logic [23:0] rem_next, fa_next;
  logic [LENGTH_BITS-1:0] left_next;
  logic done_next;
  cmd_t c;
  logic emit;
  logic [1:0] fl;
  logic [23:0] fa_upd;
  logic [1:0] idx;

  assign in_stall = q_full;
  wire acc = in_valid && !q_full;

  always_comb begin
    case (block_kind)
      4'd3: fl = 2'd3;
      4'd8: fl = 2'd0;  // 4 encoded as 0 with rem width
      4'd4, 4'd6: fl = 2'd2;
      default: fl = 2'd0;
    endcase
  end

  always_comb begin
    logic [2:0] flen;
    logic stop;
    flen = (block_kind == 4'd8) ? 3'd4 : {1'b0, fl};
    phase_next = phase;
    kind_next = block_kind;
    rem_next = block_remaining;
    fa_next = field_assembly;
    left_next = bytes_left;
    done_next = done;
    c = '0;
    c.op = OP_NONE;
    c.err = E_BAD_TYPE;
    emit = 1'b0;
    stop = 1'b0;
    idx = 2'd0;
    fa_upd = field_assembly;
    if (done || halted) begin
    end else if (bytes_left == '0) begin
      c.op = OP_END; emit = 1'b1; done_next = 1'b1;
    end else begin
      left_next = bytes_left - 1'b1;
      case (phase)
        PH_TYPE: begin
          if (in_byte == 8'd0) begin
            c.op = OP_END; emit = 1'b1; stop = 1'b1;
          end else if (in_byte > 8'h08) begin
            c.op = OP_ERR; c.err = E_BAD_TYPE; emit = 1'b1; stop = 1'b1;
          end else begin
            kind_next = in_byte[3:0];
            if (left_next < LENGTH_BITS'(3)) begin
              c.op = OP_ERR; c.err = E_NO_SIZE; emit = 1'b1; stop = 1'b1;
            end else begin
              phase_next = PH_SIZE; rem_next = 24'd3; fa_next = '0;
            end
          end
        end
        PH_SIZE: begin
          idx = 2'(3 - block_remaining[1:0]);
          if (idx > 2'd2) idx = 2'd2;
          fa_upd = field_assembly | (24'(in_byte) << (5'd8 * idx));
          fa_next = fa_upd;
          rem_next = block_remaining - 1'b1;
          if (rem_next == '0) begin
            if (32'(left_next) < 32'(fa_upd)) begin
              c.op = OP_ERR; c.err = E_TOO_LONG; emit = 1'b1; stop = 1'b1;
            end else begin
              case (block_kind)
                4'd1: begin
                  if (fa_upd < 24'd2) begin
                    c.op = OP_ERR; c.err = E_TRUNC; emit = 1'b1; stop = 1'b1;
                  end else begin
                    rem_next = fa_upd - 24'd2; phase_next = PH_RATE;
                  end
                end
                4'd2: begin
                  rem_next = fa_upd; phase_next = (fa_upd != '0) ? PH_DATA : PH_TYPE;
                end
                4'd5: begin
                  rem_next = fa_upd; phase_next = (fa_upd != '0) ? PH_SKIP : PH_TYPE;
                end
                default: begin
                  fa_next = '0; rem_next = 24'(flen);
                  phase_next = (flen != '0) ? PH_FIX : PH_TYPE;
                end
              endcase
            end
          end
        end
        PH_RATE: begin
          phase_next = PH_COMP;
        end
        PH_COMP: begin
          c.op = OP_RATE_SB; emit = 1'b1;
          c.dividend = 28'd1000000;
          c.divisor = 17'd256 - 17'(rate_byte);
          c.comp_bad = (in_byte != 8'd0);
          phase_next = (block_remaining != '0) ? PH_DATA : PH_TYPE;
        end
        PH_DATA: begin
          c.op = OP_RUN; emit = 1'b1;
          c.sample = {in_byte ^ 8'h80, 8'h00};
          c.run = 17'd1;
          rem_next = block_remaining - 1'b1;
          if (rem_next == '0) phase_next = PH_TYPE;
        end
        PH_SKIP: begin
          rem_next = block_remaining - 1'b1;
          if (rem_next == '0) phase_next = PH_TYPE;
        end
        PH_FIX: begin
          idx = 2'(flen - block_remaining[2:0]);
          if (idx < 2'd2) fa_upd = field_assembly | (24'(in_byte) << (5'd8 * idx));
          fa_next = fa_upd;
          rem_next = block_remaining - 1'b1;
          if (rem_next == '0) begin
            phase_next = PH_TYPE;
            if (block_kind == 4'd3) begin
              c.op = OP_RUN; emit = 1'b1;
              c.run = 17'(fa_upd[15:0]) + 17'd1;
            end else if (block_kind == 4'd8) begin
              c.op = OP_RATE_TC; emit = 1'b1;
              c.dividend = (in_byte != 8'd0) ? 28'd128000000 : 28'd256000000;
              c.divisor = 17'd65536 - 17'(fa_upd[15:0]);
            end
          end
        end
        default: phase_next = PH_TYPE;
      endcase
      if (!stop && left_next == '0) begin
        c.tail = 1'b1;
        c.tail_end = (phase_next == PH_TYPE);
        if (!emit) begin
          c.op = OP_NONE; emit = 1'b1;
        end
        stop = 1'b1;
      end
      if (stop) done_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase <= PH_TYPE;
      block_kind <= '0;
      block_remaining <= '0;
      bytes_left <= rst ? '0 : length;
      field_assembly <= '0;
      rate_byte <= '0;
      done <= 1'b0;
    end else if (acc) begin
      phase <= phase_next;
      block_kind <= kind_next;
      block_remaining <= rem_next;
      bytes_left <= left_next;
      field_assembly <= fa_next;
      done <= done_next;
      if (phase == PH_RATE && !done && !halted && bytes_left != '0) rate_byte <= in_byte;
    end
  end

  assign q_valid = acc && emit;
  assign q_cmd = c;
endmodule

// ----- design/vbsd_back.sv -----
`timescale 1ns / 1ps
module vbsd_back import vbsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        halted,
  output logic        out_valid,
  output res_t        out_res,
  input  logic        out_stall
);
  // results in order: main, optional comp error, optional tail
  status_t status;
  logic [27:0] stored_rate;
  logic busy;  // dividing
  logic div_ready;  // quotient held for the command at the head
  logic [4:0] cnt;
  logic [27:0] quo, rem_r;
  logic [16:0] dvs;
  logic [1:0] step;  // 0 main,1 comp,2 tail
  logic ov;
  res_t ob;

  logic [28:0] trial;
  assign trial = {rem_r, quo[27]} - {12'd0, dvs};

  wire can = !ov || !out_stall;
  assign out_valid = ov;
  assign out_res = ob;
  assign halted = (status != ST_RUN);

  wire div_op = q_cmd.op == OP_RATE_SB || q_cmd.op == OP_RATE_TC;

  always_ff @(posedge clk) begin
    logic has_more;
    res_t r;
    status_t st;
    if (rst || restart) begin
      status <= ST_RUN; stored_rate <= '0; busy <= 1'b0; ov <= 1'b0;
      step <= 2'd0; cnt <= '0; q_pop <= 1'b0; div_ready <= 1'b0;
    end else begin
      q_pop <= 1'b0;
      if (ov && !out_stall) ov <= 1'b0;
      if (q_valid && !q_pop && status == ST_RUN && div_op && !busy && step == 2'd0 &&
          !div_ready) begin
        busy <= 1'b1; cnt <= 5'd28; quo <= q_cmd.dividend; rem_r <= '0;
        dvs <= q_cmd.divisor;
      end else if (busy) begin
        if (!trial[28]) begin
          rem_r <= trial[27:0]; quo <= {quo[26:0], 1'b1};
        end else begin
          rem_r <= {rem_r[26:0], quo[27]}; quo <= {quo[26:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          div_ready <= 1'b1;
        end
      end else if (q_valid && !q_pop && status == ST_RUN && can) begin
        r = '0; st = status; has_more = 1'b0;
        r.kind = 3'(K_ERR);
        case (step)
          2'd0: begin
            case (q_cmd.op)
              OP_RUN: begin r.kind = 3'(K_RUN); r.sample = q_cmd.sample; r.run = q_cmd.run; end
              OP_END: begin r.kind = 3'(K_END); st = ST_END; end
              OP_ERR: begin r.err = 3'(q_cmd.err); st = ST_ERR; end
              OP_RATE_SB, OP_RATE_TC: begin
                if (stored_rate != '0 && stored_rate != quo) begin
                  r.err = 3'(E_CONFLICT); st = ST_ERR;
                end else begin
                  r.kind = 3'(K_RATE); r.rate = quo; stored_rate <= quo;
                  if (q_cmd.op == OP_RATE_SB && q_cmd.comp_bad) has_more = 1'b1;
                end
              end
              default: r.kind = 3'd4;  // nothing to show
            endcase
            if (st == ST_RUN && q_cmd.tail) has_more = 1'b1;
            step <= has_more ? ((q_cmd.op == OP_RATE_SB && q_cmd.comp_bad &&
                                 st == ST_RUN) ? 2'd1 : 2'd2) : 2'd0;
          end
          2'd1: begin
            r.err = 3'(E_COMPRESS); st = ST_ERR; step <= 2'd0;
          end
          default: begin
            if (q_cmd.tail_end) begin r.kind = 3'(K_END); st = ST_END; end
            else begin r.err = 3'(E_TRUNC); st = ST_ERR; end
            step <= 2'd0;
          end
        endcase
        r.last = !has_more;
        status <= st;
        if (r.kind != 3'd4) begin ob <= r; ov <= 1'b1; end
        if (!has_more) begin q_pop <= 1'b1; div_ready <= 1'b0; end
      end else if (q_valid && !q_pop && status != ST_RUN) begin
        q_pop <= 1'b1; step <= 2'd0; div_ready <= 1'b0;
      end
    end
  end
endmodule

// ----- design/vbsd_queue.sv -----
`timescale 1ns / 1ps
module vbsd_queue import vbsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output logic valid,
  output cmd_t dout,
  output logic full
);
  cmd_t m0, m1;
  logic [1:0] n;
  assign valid = n != 2'd0;
  assign dout = m0;
  // one slot reserved so a push never lands while popping is uncertain
  assign full = n != 2'd0;
  always_ff @(posedge clk) begin
    if (rst) n <= '0;
    else begin
      if (pop && push) begin m0 <= din; end
      else if (pop) begin n <= n - 1'b1; m0 <= m1; end
      else if (push) begin
        if (n == 2'd0) m0 <= din; else m1 <= din;
        n <= n + 1'b1;
      end
    end
  end
endmodule
